// ----- hdl/llnp_pkg.sv -----
package llnp_pkg;

  // default pool depth
  localparam int POOL_NODES_DEF = 16;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_NO_SUCC = 2'd3;

  // cleared node contents
  localparam logic [31:0] ID_MINUS_ONE    = 32'hFFFF_FFFF;
  localparam logic [31:0] GRADE_MINUS_ONE = 32'hBF80_0000;

  // one operation beat
  typedef struct packed {
    logic [1:0]         func;
    logic               at_head;
    logic [3:0]         pred_index;
    logic signed [31:0] item_id;
    logic [31:0]        item_grade;
    logic [3:0]         read_index;
  } op_t;

  // one result beat
  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic               head_valid;
    logic [3:0]         head_index;
    logic               free_valid;
    logic [3:0]         free_index;
    logic signed [31:0] read_id;
    logic [31:0]        read_grade;
    logic               read_next_valid;
    logic [3:0]         read_next_index;
  } res_t;

endpackage

// ----- hdl/llnp_in_reg.sv -----
module llnp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  llnp_pkg::op_t  in_op,
  output logic           op_valid,
  output llnp_pkg::op_t  op,
  input  logic           op_take
);

  logic          valid_r;
  logic          valid_nxt;
  llnp_pkg::op_t op_r;

  // register is free when empty or drained this cycle
  assign in_ready  = !valid_r || op_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_op;
    end
  end

  assign op_valid = valid_r;
  assign op       = op_r;

endmodule

// ----- hdl/llnp_out_reg.sv -----
module llnp_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_load,
  input  llnp_pkg::res_t  res,
  output logic            res_free,
  output logic            out_valid,
  input  logic            out_ready,
  output llnp_pkg::res_t  out_res
);

  logic           valid_r;
  logic           valid_nxt;
  llnp_pkg::res_t res_r;

  // room for a new result when empty or being taken
  assign res_free  = !valid_r || out_ready;
  assign valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- hdl/llnp_engine.sv -----
module llnp_engine #(
  parameter int POOL_NODES = llnp_pkg::POOL_NODES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            commit,
  input  llnp_pkg::op_t   op,
  output llnp_pkg::res_t  res
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int CW = NW + 5;
  localparam logic [CW-1:0] NODE_COUNT = CW'(POOL_NODES);

  // node store and list pointers
  logic          nv_r     [POOL_NODES];
  logic [NW-1:0] nl_r     [POOL_NODES];
  logic [31:0]   ids_r    [POOL_NODES];
  logic [31:0]   grades_r [POOL_NODES];
  logic          head_v_r;
  logic [NW-1:0] head_p_r;
  logic          free_v_r;
  logic [NW-1:0] free_p_r;

  logic          head_v_nxt;
  logic [NW-1:0] head_p_nxt;
  logic          free_v_nxt;
  logic [NW-1:0] free_p_nxt;

  // two link write ports, port b wins on the same entry
  logic          wa_en;
  logic [NW-1:0] wa_addr;
  logic          wa_v;
  logic [NW-1:0] wa_link;
  logic          wb_en;
  logic [NW-1:0] wb_addr;
  logic          wb_v;
  logic [NW-1:0] wb_link;

  // node contents write
  logic          nd_en;
  logic [NW-1:0] nd_addr;
  logic [31:0]   nd_id;
  logic [31:0]   nd_grade;

  logic [NW+3:0] pred_ext;
  logic [NW+3:0] rd_ext;
  logic [NW-1:0] pred_n;
  logic [NW-1:0] rd_n;
  logic          pred_ok;
  logic          rd_ok;
  logic [NW-1:0] node_t;

  logic [1:0]    status;
  logic [NW-1:0] slot_n;
  logic [31:0]   r_id;
  logic [31:0]   r_grade;
  logic          r_nv;
  logic [NW-1:0] r_nl;

  logic [NW+3:0] slot_ext;
  logic [NW+3:0] head_ext;
  logic [NW+3:0] free_ext;
  logic [NW+3:0] rnl_ext;

  // index fields to node indices, with range checks
  assign pred_ext = {{NW{1'b0}}, op.pred_index};
  assign rd_ext   = {{NW{1'b0}}, op.read_index};
  assign pred_n   = pred_ext[NW-1:0];
  assign rd_n     = rd_ext[NW-1:0];
  assign pred_ok  = CW'(op.pred_index) < NODE_COUNT;
  assign rd_ok    = CW'(op.read_index) < NODE_COUNT;

  // operation decode and pointer updates
  always_comb begin
    status     = llnp_pkg::STATUS_OK;
    slot_n     = '0;
    node_t     = '0;
    head_v_nxt = head_v_r;
    head_p_nxt = head_p_r;
    free_v_nxt = free_v_r;
    free_p_nxt = free_p_r;
    wa_en      = 1'b0;
    wa_addr    = '0;
    wa_v       = 1'b0;
    wa_link    = '0;
    wb_en      = 1'b0;
    wb_addr    = '0;
    wb_v       = 1'b0;
    wb_link    = '0;
    nd_en      = 1'b0;
    nd_addr    = '0;
    nd_id      = '0;
    nd_grade   = '0;
    r_id       = '0;
    r_grade    = '0;
    r_nv       = 1'b0;
    r_nl       = '0;
    case (op.func)
      llnp_pkg::FUNC_INSERT: begin
        if (!free_v_r) begin
          status = llnp_pkg::STATUS_FULL;
        end else if (!op.at_head && !pred_ok) begin
          status = llnp_pkg::STATUS_NO_SUCC;
        end else begin
          node_t     = free_p_r;
          free_v_nxt = nv_r[node_t];
          free_p_nxt = nl_r[node_t];
          nd_en      = 1'b1;
          nd_addr    = node_t;
          nd_id      = op.item_id;
          nd_grade   = op.item_grade;
          if (op.at_head) begin
            wb_en      = 1'b1;
            wb_addr    = node_t;
            wb_v       = head_v_r;
            wb_link    = head_p_r;
            head_v_nxt = 1'b1;
            head_p_nxt = node_t;
          end else begin
            // new node takes the predecessor's link, then predecessor points at it
            wa_en   = 1'b1;
            wa_addr = node_t;
            wa_v    = nv_r[pred_n];
            wa_link = nl_r[pred_n];
            wb_en   = 1'b1;
            wb_addr = pred_n;
            wb_v    = 1'b1;
            wb_link = node_t;
          end
          slot_n = node_t;
        end
      end
      llnp_pkg::FUNC_DELETE: begin
        if (!head_v_r) begin
          status = llnp_pkg::STATUS_EMPTY;
        end else if (!op.at_head && (!pred_ok || !nv_r[pred_n])) begin
          status = llnp_pkg::STATUS_NO_SUCC;
        end else begin
          if (op.at_head) begin
            node_t     = head_p_r;
            head_v_nxt = nv_r[node_t];
            head_p_nxt = nl_r[node_t];
          end else begin
            node_t  = nl_r[pred_n];
            wa_en   = 1'b1;
            wa_addr = pred_n;
            wa_v    = nv_r[node_t];
            wa_link = nl_r[node_t];
          end
          // released node goes on top of the free list
          wb_en      = 1'b1;
          wb_addr    = node_t;
          wb_v       = free_v_r;
          wb_link    = free_p_r;
          nd_en      = 1'b1;
          nd_addr    = node_t;
          nd_id      = llnp_pkg::ID_MINUS_ONE;
          nd_grade   = llnp_pkg::GRADE_MINUS_ONE;
          free_v_nxt = 1'b1;
          free_p_nxt = node_t;
          slot_n     = node_t;
        end
      end
      llnp_pkg::FUNC_READ: begin
        if (!rd_ok) begin
          status = llnp_pkg::STATUS_NO_SUCC;
        end else begin
          r_id    = ids_r[rd_n];
          r_grade = grades_r[rd_n];
          r_nv    = nv_r[rd_n];
          r_nl    = nv_r[rd_n] ? nl_r[rd_n] : '0;
        end
      end
      default: begin
        status = llnp_pkg::STATUS_OK;
      end
    endcase
  end

  // node indices back to the 4-bit result fields
  assign slot_ext = {4'b0, slot_n};
  assign head_ext = {4'b0, head_v_nxt ? head_p_nxt : {NW{1'b0}}};
  assign free_ext = {4'b0, free_v_nxt ? free_p_nxt : {NW{1'b0}}};
  assign rnl_ext  = {4'b0, r_nl};

  always_comb begin
    res.status          = status;
    res.slot            = slot_ext[3:0];
    res.head_valid      = head_v_nxt;
    res.head_index      = head_ext[3:0];
    res.free_valid      = free_v_nxt;
    res.free_index      = free_ext[3:0];
    res.read_id         = r_id;
    res.read_grade      = r_grade;
    res.read_next_valid = r_nv;
    res.read_next_index = rnl_ext[3:0];
  end

  // state commit; reset chains every node into the free list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_NODES; i++) begin
        nv_r[i]     <= (i + 1 < POOL_NODES);
        nl_r[i]     <= (i + 1 < POOL_NODES) ? NW'(i + 1) : '0;
        ids_r[i]    <= llnp_pkg::ID_MINUS_ONE;
        grades_r[i] <= llnp_pkg::GRADE_MINUS_ONE;
      end
      head_v_r <= 1'b0;
      head_p_r <= '0;
      free_v_r <= 1'b1;
      free_p_r <= '0;
    end else if (commit) begin
      head_v_r <= head_v_nxt;
      head_p_r <= head_p_nxt;
      free_v_r <= free_v_nxt;
      free_p_r <= free_p_nxt;
      for (int i = 0; i < POOL_NODES; i++) begin
        if (wb_en && wb_addr == NW'(i)) begin
          nv_r[i] <= wb_v;
          nl_r[i] <= wb_link;
        end else if (wa_en && wa_addr == NW'(i)) begin
          nv_r[i] <= wa_v;
          nl_r[i] <= wa_link;
        end
        if (nd_en && nd_addr == NW'(i)) begin
          ids_r[i]    <= nd_id;
          grades_r[i] <= nd_grade;
        end
      end
    end
  end

endmodule

// ----- hdl/linked_list_node_pool_core.sv -----
// Singly linked list in a fixed node pool, with a free list threaded
// through the same next links.
// Input channel (in_*): one operation per beat; in_tuser carries the
// operation code (insert, delete, read node), in_tdata the operands.
// Result channel (out_*): exactly one result beat per operation, in order;
// out_tuser carries the status, out_tdata the slot, head and free pointers
// after the operation and the contents of a read node.
// Path: the input register holds each operation until the result register
// has room; the operation then moves into the result register, which
// presents the result beat.
// Throughput: one operation per cycle while the result register is not held
// by out_tready low; each operation's pointer and node updates are done in
// the cycle that moves it from the input register into the result register.
// Reset: every node is chained into the free list, ids set to -1 and
// grades to float -1.0, the list is empty; the block takes beats as soon as
// reset is released.
// Stall: a result held by out_tready low keeps its register; the input
// register still takes one more beat if it is empty, then in_tready drops
// until the result is taken.
module linked_list_node_pool_core #(
  parameter int POOL_NODES = llnp_pkg::POOL_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // at_head, pred_index[3:0], item_id[31:0], item_grade[31:0], read_index[3:0]
  input  logic [79:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[3:0], head_valid, head_index[3:0], free_valid, free_index[3:0],
  // read_id[31:0], read_grade[31:0], read_next_valid, read_next_index[3:0]
  output logic [87:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser
);

  llnp_pkg::op_t  in_op;
  llnp_pkg::op_t  op;
  llnp_pkg::res_t res;
  llnp_pkg::res_t out_res;
  logic           op_valid;
  logic           res_free;
  logic           commit;

  // unpack the input beat
  always_comb begin
    in_op.func       = in_tuser;
    in_op.at_head    = in_tdata[0];
    in_op.pred_index = in_tdata[4:1];
    in_op.item_id    = in_tdata[36:5];
    in_op.item_grade = in_tdata[68:37];
    in_op.read_index = in_tdata[72:69];
  end

  assign commit = op_valid && res_free;

  llnp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_op),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (commit)
  );

  llnp_engine #(
    .POOL_NODES (POOL_NODES)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .op     (op),
    .res    (res)
  );

  llnp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (commit),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack the result beat
  assign out_tuser = out_res.status;
  assign out_tdata = {5'b0, out_res.read_next_index, out_res.read_next_valid,
                      out_res.read_grade, out_res.read_id, out_res.free_index,
                      out_res.free_valid, out_res.head_index, out_res.head_valid,
                      out_res.slot};

  // an empty result register never blocks the input side
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // a released node becomes the free-list head
  a_delete_frees_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op.func == llnp_pkg::FUNC_DELETE && res.status == llnp_pkg::STATUS_OK)
      |-> (res.free_valid && res.free_index == res.slot))
    else $error("released node is not the free-list head");

  // a full pool reports no free node
  a_full_no_free : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res.status == llnp_pkg::STATUS_FULL) |-> !res.free_valid)
    else $error("pool full reported with a free node");

  // read fields stay zero for anything but a read
  a_read_fields_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op.func != llnp_pkg::FUNC_READ)
      |-> (res.read_id == 0 && res.read_grade == 0 && !res.read_next_valid))
    else $error("read fields set outside a read");

endmodule
